### rtl/resp_command_parser_defines.svh
// Assertion macros for the request parser RTL, used by its top level.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef RESP_COMMAND_PARSER_DEFINES_SVH
`define RESP_COMMAND_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RCP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("resp parser check failed");

// Next-cycle implication, disabled while reset is high.
`define RCP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("resp parser check failed");

`endif

### rtl/rcp_pkg.sv
// Types and constants for the request parser.
// Used by every module of the parser; depends on nothing else.
`default_nettype none

package rcp_pkg;

  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  localparam logic [12:0] ACC_MAX = 13'd8191;
  localparam logic [12:0] LEN_CAP = 13'd4096;

  localparam logic [1:0] REG_ARG_LIMIT    = 2'd0;
  localparam logic [1:0] REG_LENGTH_LIMIT = 2'd1;

  localparam logic [3:0]  ARG_LIMIT_RST    = 4'd4;
  localparam logic [12:0] LENGTH_LIMIT_RST = 13'd100;

  localparam logic [2:0] ERR_NO_STAR       = 3'd0;
  localparam logic [2:0] ERR_BAD_COUNT_END = 3'd1;
  localparam logic [2:0] ERR_TOO_MANY      = 3'd2;
  localparam logic [2:0] ERR_NO_DOLLAR     = 3'd3;
  localparam logic [2:0] ERR_BAD_LEN_END   = 3'd4;
  localparam logic [2:0] ERR_TOO_LONG      = 3'd5;
  localparam logic [2:0] ERR_NO_CRLF       = 3'd6;
  localparam logic [2:0] ERR_EARLY_END     = 3'd7;

  typedef enum logic [9:0] {
    PH_IDLE     = 10'b00_0000_0001,
    PH_COUNT    = 10'b00_0000_0010,
    PH_COUNT_LF = 10'b00_0000_0100,
    PH_DOLLAR   = 10'b00_0000_1000,
    PH_LEN      = 10'b00_0001_0000,
    PH_LEN_LF   = 10'b00_0010_0000,
    PH_PAYLOAD  = 10'b00_0100_0000,
    PH_END_CR   = 10'b00_1000_0000,
    PH_END_LF   = 10'b01_0000_0000,
    PH_DRAIN    = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic [3:0]  arg_limit;
    logic [12:0] length_limit;
  } cfg_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [3:0]  arg_index;
    logic        arg_done;
    logic [11:0] arg_length;
    logic        command_done;
    logic [3:0]  arg_count;
    logic        parse_error;
    logic [2:0]  error_code;
  } result_t;

endpackage

`default_nettype wire

### rtl/rcp_cfg_regs.sv
// Configuration registers of the request parser.
// Depends on rcp_pkg for register indexes and reset values.
`default_nettype none

module rcp_cfg_regs
  import rcp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data,
  output      cfg_t        cfg
);

  cfg_t cfg_reg;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.arg_limit    <= ARG_LIMIT_RST;
      cfg_reg.length_limit <= LENGTH_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ARG_LIMIT:    cfg_reg.arg_limit    <= cfg_data[3:0];
        REG_LENGTH_LIMIT: cfg_reg.length_limit <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/rcp_parser.sv
// Framing state machine of the request parser: one byte per step.
// Depends on rcp_pkg for phases, characters, error codes and the result type.
`default_nettype none

module rcp_parser
  import rcp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] data_byte,
  input  wire cfg_t       cfg,
  output      logic       res_valid,
  output      result_t    res
);

  phase_t      phase, phase_next;
  logic [12:0] acc, acc_next;
  logic [3:0]  expected_args, expected_args_next;
  logic [3:0]  current_arg, current_arg_next;
  logic [11:0] declared_length, declared_length_next;
  logic [11:0] bytes_remaining, bytes_remaining_next;

  logic        digit;
  logic [16:0] acc_sum;
  logic [12:0] acc_sat;
  logic [12:0] len_lim;
  logic [3:0]  arg_inc;
  logic        raise;
  logic [2:0]  code;

  // acc * 10 + digit as two shifts and two adds, then saturate.
  assign digit   = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
  assign acc_sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {13'd0, data_byte[3:0]};
  assign acc_sat = (acc_sum > {4'd0, ACC_MAX}) ? ACC_MAX : acc_sum[12:0];
  assign len_lim = (cfg.length_limit > LEN_CAP) ? LEN_CAP : cfg.length_limit;
  assign arg_inc = current_arg + 4'd1;

  always_comb begin
    phase_next           = phase;
    acc_next             = acc;
    expected_args_next   = expected_args;
    current_arg_next     = current_arg;
    declared_length_next = declared_length;
    bytes_remaining_next = bytes_remaining;
    res                  = '0;
    res_valid            = 1'b0;
    raise                = 1'b0;
    code                 = ERR_NO_STAR;

    if (phase != PH_IDLE && phase != PH_DRAIN && data_byte == CHAR_NUL) begin
      raise = 1'b1;
      code  = ERR_EARLY_END;
    end else begin
      unique case (phase)
        PH_DRAIN: begin
          if (data_byte == CHAR_NUL) phase_next = PH_IDLE;
        end
        PH_IDLE: begin
          if (data_byte != CHAR_STAR) begin
            raise = 1'b1;
            code  = ERR_NO_STAR;
          end else begin
            acc_next   = '0;
            phase_next = PH_COUNT;
          end
        end
        PH_COUNT: begin
          if (digit) begin
            acc_next = acc_sat;
          end else if (data_byte != CHAR_CR) begin
            raise = 1'b1;
            code  = ERR_BAD_COUNT_END;
          end else begin
            phase_next = PH_COUNT_LF;
          end
        end
        PH_COUNT_LF: begin
          if (data_byte != CHAR_LF) begin
            raise = 1'b1;
            code  = ERR_BAD_COUNT_END;
          end else if (acc > {9'd0, cfg.arg_limit}) begin
            raise = 1'b1;
            code  = ERR_TOO_MANY;
          end else begin
            expected_args_next = acc[3:0];
            current_arg_next   = '0;
            if (acc[3:0] == 4'd0) begin
              // An empty command finishes right at its header.
              res.command_done = 1'b1;
              res_valid        = 1'b1;
              phase_next       = PH_DRAIN;
            end else begin
              phase_next = PH_DOLLAR;
            end
          end
        end
        PH_DOLLAR: begin
          if (data_byte != CHAR_DOLLAR) begin
            raise = 1'b1;
            code  = ERR_NO_DOLLAR;
          end else begin
            acc_next   = '0;
            phase_next = PH_LEN;
          end
        end
        PH_LEN: begin
          if (digit) begin
            acc_next = acc_sat;
          end else if (data_byte != CHAR_CR) begin
            raise = 1'b1;
            code  = ERR_BAD_LEN_END;
          end else begin
            phase_next = PH_LEN_LF;
          end
        end
        PH_LEN_LF: begin
          if (data_byte != CHAR_LF) begin
            raise = 1'b1;
            code  = ERR_BAD_LEN_END;
          end else if (acc >= len_lim) begin
            raise = 1'b1;
            code  = ERR_TOO_LONG;
          end else begin
            declared_length_next = acc[11:0];
            bytes_remaining_next = acc[11:0];
            phase_next = (acc[11:0] == 12'd0) ? PH_END_CR : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          res.payload_valid    = 1'b1;
          res.payload_byte     = data_byte;
          res.arg_index        = current_arg;
          res_valid            = 1'b1;
          bytes_remaining_next = bytes_remaining - 12'd1;
          if (bytes_remaining == 12'd1) phase_next = PH_END_CR;
        end
        PH_END_CR: begin
          if (data_byte != CHAR_CR) begin
            raise = 1'b1;
            code  = ERR_NO_CRLF;
          end else begin
            phase_next = PH_END_LF;
          end
        end
        PH_END_LF: begin
          if (data_byte != CHAR_LF) begin
            raise = 1'b1;
            code  = ERR_NO_CRLF;
          end else begin
            res.arg_index    = current_arg;
            res.arg_done     = 1'b1;
            res.arg_length   = declared_length;
            res_valid        = 1'b1;
            current_arg_next = arg_inc;
            if (arg_inc == expected_args) begin
              res.command_done = 1'b1;
              res.arg_count    = expected_args;
              phase_next       = PH_DRAIN;
            end else begin
              phase_next = PH_DOLLAR;
            end
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end

    if (raise) begin
      res             = '0;
      res.parse_error = 1'b1;
      res.error_code  = code;
      res_valid       = 1'b1;
      phase_next      = (data_byte == CHAR_NUL) ? PH_IDLE : PH_DRAIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      acc             <= '0;
      expected_args   <= '0;
      current_arg     <= '0;
      declared_length <= '0;
      bytes_remaining <= '0;
    end else if (step) begin
      phase           <= phase_next;
      acc             <= acc_next;
      expected_args   <= expected_args_next;
      current_arg     <= current_arg_next;
      declared_length <= declared_length_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

endmodule

`default_nettype wire

### rtl/rcp_out_reg.sv
// Result register of the request parser, holding one word for the output side.
// Depends on rcp_pkg for the result type.
`default_nettype none

module rcp_out_reg
  import rcp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t load_data,
  input  wire logic    take,
  output      logic    full,
  output      result_t data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

`default_nettype wire

### rtl/resp_command_parser.sv
// Top level of the array-of-bulk-strings request parser.
// Depends on rcp_pkg, rcp_cfg_regs, rcp_parser, rcp_out_reg and the defines header.
//
//   Channel  Direction  Word contents
//   s_*      in         tdata[7:0] data_byte
//   m_*      out        tdata: payload byte, argument index, length, count, error code;
//                       tuser: payload_valid, arg_done, command_done, parse_error
//   cfg_*    in         cfg_index selects arg_limit (0) or length_limit (1)
//
// Each byte is held in the input register and is parsed as it leaves it,
// so the block sustains one byte per clock while the output side keeps taking words.
// A byte that yields a result loads the output register; other bytes just advance state.
// A stall on the output side holds the input register, and s_tready drops only when both
// the input register and the output register are full.
// Reset is synchronous and puts the parser in the idle phase with default limits.
`default_nettype none

`include "resp_command_parser_defines.svh"

module resp_command_parser
  import rcp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Input bytes. s_tdata: [7:0] data_byte.
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [7:0]  s_tdata,
  // Results. m_tdata: [7:0] payload_byte, [11:8] arg_index, [23:12] arg_length,
  // [27:24] arg_count, [30:28] error_code, [31] zero.
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [31:0] m_tdata,
  // m_tuser: [0] payload_valid, [1] arg_done, [2] command_done, [3] parse_error.
  output      logic [3:0]  m_tuser,
  // Configuration writes.
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);

  cfg_t    cfg;
  result_t res;
  result_t out_data;
  logic    res_valid;
  logic    in_full;
  logic    [7:0] in_byte;
  logic    advance;
  logic    out_load;

  rcp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The held byte is parsed once the output register has room for its result.
  assign advance  = in_full && (!m_tvalid || m_tready);
  assign s_tready = !in_full || advance;
  assign out_load = advance && res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  rcp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  rcp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (out_load),
    .load_data (res),
    .take      (m_tready),
    .full      (m_tvalid),
    .data      (out_data)
  );

  assign m_tdata = {1'b0, out_data.error_code, out_data.arg_count, out_data.arg_length,
                    out_data.arg_index, out_data.payload_byte};
  assign m_tuser = {out_data.parse_error, out_data.command_done, out_data.arg_done,
                    out_data.payload_valid};

  // Every word is exactly one kind: a payload byte, an argument or command end, or an error.
  `RCP_ASSERT_IMP(a_one_kind, m_tvalid,
    $onehot({m_tuser[0], m_tuser[1] | m_tuser[2], m_tuser[3]}))
  // Closing the last argument reports the count as one past its index.
  `RCP_ASSERT_IMP(a_last_arg_count, m_tvalid && m_tuser[1] && m_tuser[2],
    m_tdata[27:24] == m_tdata[11:8] + 4'd1)
  // The error code is clear unless the word reports an error.
  `RCP_ASSERT_IMP(a_code_clear, m_tvalid && !m_tuser[3], m_tdata[30:28] == ERR_NO_STAR)
  // A taken word with nothing behind it leaves the output empty.
  `RCP_ASSERT_NXT(a_drain_out, m_tvalid && m_tready && !out_load, !m_tvalid)

endmodule

`default_nettype wire
